@@ src/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps

package dq_pkg;

   localparam int DEPTH_DEFAULT = 1024;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_POP_BACK   = 3'd4;

   localparam logic [31:0] NO_WORD = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] push_value;
   } dq_req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic               underflow;
      logic               overflow;
      logic [10:0]        entry_count;
      logic               is_empty;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } dq_rsp_type;

endpackage

@@ src/dq_ram.sv @@
// Ring storage: one write port, two registered read ports.
`timescale 1ns / 1ps

module dq_ram import dq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [31:0]   rd_data_a,
   output logic [31:0]   rd_data_b
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ src/dq_ctrl.sv @@
// Queue sequencer: pointer and count update, memory addressing, result register.
`timescale 1ns / 1ps

module dq_ctrl import dq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dq_req_type    req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dq_rsp_type    rsp_data,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [31:0]   wr_data,
   output logic [AW-1:0] rd_addr_a,
   output logic [AW-1:0] rd_addr_b,
   input  logic [31:0]   rd_data_a,
   input  logic [31:0]   rd_data_b
);

   localparam int SW = AW + 2;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

   typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_READ, S_FINISH} state_type;

   state_type     state_ff;
   logic [2:0]    op_ff;
   logic [31:0]   val_ff;
   logic [AW-1:0] front_ff;
   logic [CW-1:0] count_ff;
   logic          under_ff;
   logic          over_ff;
   logic          pop_ok_ff;
   logic [31:0]   popped_ff;
   logic          rsp_valid_ff;
   dq_rsp_type    rsp_ff;

   logic          is_push, is_pop, full, empty;
   logic          rsp_load;
   logic [AW-1:0] front_inc, front_dec, back_addr, tail_addr;
   logic [SW-1:0] back_sum, tail_sum;
   logic [CW+10:0] count_ext;

   assign is_push = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_PUSH_BACK);
   assign is_pop  = (op_ff == OP_POP_FRONT) || (op_ff == OP_POP_BACK);
   assign full    = (count_ff == DEPTH_C);
   assign empty   = (count_ff == '0);

   assign front_inc = (front_ff == LAST_A) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? LAST_A : front_ff - 1'b1;

   // back = front + count - 1, tail = front + count, both mod DEPTH
   always_comb begin
      back_sum = SW'(front_ff) + SW'(count_ff) - SW'(1);
      tail_sum = SW'(front_ff) + SW'(count_ff);
      if (back_sum >= DEPTH_S) begin
         back_sum = back_sum - DEPTH_S;
      end
      if (tail_sum >= DEPTH_S) begin
         tail_sum = tail_sum - DEPTH_S;
      end
      back_addr = back_sum[AW-1:0];
      tail_addr = tail_sum[AW-1:0];
   end

   assign wr_en     = (state_ff == S_UPDATE) && is_push && !full;
   assign wr_addr   = (op_ff == OP_PUSH_FRONT) ? front_dec : tail_addr;
   assign wr_data   = val_ff;
   assign rd_addr_a = ((state_ff == S_UPDATE) && (op_ff == OP_POP_BACK)) ? back_addr
                                                                          : front_ff;
   assign rd_addr_b = back_addr;

   assign count_ext = (CW + 11)'(count_ff);

   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_data.opcode;
                  val_ff   <= req_data.push_value;
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               under_ff  <= is_pop && empty;
               over_ff   <= is_push && full;
               pop_ok_ff <= is_pop && !empty;
               if (is_push && !full) begin
                  count_ff <= count_ff + 1'b1;
                  if (op_ff == OP_PUSH_FRONT) begin
                     front_ff <= front_dec;
                  end
               end else if (is_pop && !empty) begin
                  count_ff <= count_ff - 1'b1;
                  if (op_ff == OP_POP_FRONT) begin
                     front_ff <= front_inc;
                  end
               end
               state_ff <= S_READ;
            end
            S_READ: begin
               popped_ff <= pop_ok_ff ? rd_data_a : NO_WORD;
               state_ff  <= S_FINISH;
            end
            S_FINISH: begin
               if (rsp_load) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.popped_value  <= popped_ff;
                  rsp_ff.underflow     <= under_ff;
                  rsp_ff.overflow      <= over_ff;
                  rsp_ff.entry_count   <= count_ext[10:0];
                  rsp_ff.is_empty      <= empty;
                  rsp_ff.front_value   <= empty ? NO_WORD : rd_data_a;
                  rsp_ff.back_value    <= empty ? NO_WORD : rd_data_b;
                  state_ff             <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("write without count increment");

   a_underflow_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.underflow |-> rsp_ff.popped_value == NO_WORD)
      else $error("underflow with popped word");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.underflow && rsp_ff.overflow))
      else $error("underflow and overflow together");

endmodule

@@ src/double_ended_queue.sv @@
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  dq_req_type (opcode, push_value)
//   rsp      out        rsp_valid / rsp_ready  dq_rsp_type (popped, flags, count,
//                                              front, back)
//
// Each operation passes through accept, pointer update with the memory write or
// pop read, front/back read and result load, in that order. The next request is
// taken only once the previous result has been loaded into the output register.
// The memory read ports are registered; front/back can only be read once the
// pointers are updated.
// Synchronous reset empties the queue; memory contents are not cleared.
// A stalled result holds in the output register; the next request is taken
// meanwhile, and its result waits until the register frees.
`timescale 1ns / 1ps

module double_ended_queue import dq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dq_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dq_rsp_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   logic [31:0]   rd_data_a;
   logic [31:0]   rd_data_b;

   dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   dq_ram #(.DEPTH(DEPTH)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

endmodule
